>>> design/sprite_frame_sequencer_assert.svh
// Assertion macros for the sprite frame sequencer.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SFS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfs assertion failed");

`define SFS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfs assertion failed");

`else

`define SFS_ASSERT_IMP(name, clk, rst, ante, cons)

`define SFS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

>>> design/sfs_pkg.sv
`timescale 1ns / 1ps

package sfs_pkg;

  localparam int CMD_W      = 3;
  localparam int TIME_W     = 32;
  localparam int FRAME_W    = 16;
  localparam int GEOM_W     = 13;
  localparam int AREA_W     = 2 * GEOM_W;
  localparam int MUL_W      = GEOM_W + FRAME_W;
  localparam int COORD_W    = 24;
  localparam int CD_W       = 34;
  localparam int STATUS_W   = 2;
  localparam int LIST_POS_W = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W  = $clog2(FRAME_W + 1);

  localparam int MAX_LIST_DEFAULT = 64;

  localparam logic [GEOM_W-1:0] GEOM_RESET  = GEOM_W'(1);
  localparam logic [TIME_W-1:0] DELAY_RESET = TIME_W'(26214);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_START  = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_RESUME = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_RANGE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY   = 3'd4;

  typedef struct packed {
    logic               start;
    logic [FRAME_W-1:0] dividend;
    logic [GEOM_W-1:0]  divisor;
  } sfs_div_req_t;

  typedef struct packed {
    logic               done;
    logic [FRAME_W-1:0] quotient;
    logic [GEOM_W-1:0]  remainder;
  } sfs_div_resp_t;

endpackage

>>> design/sfs_cmd_if.sv
`timescale 1ns / 1ps

interface sfs_cmd_if import sfs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [TIME_W-1:0]  time_step;
  logic [FRAME_W-1:0] frame_number;
  logic               once_mode;

  modport source (output valid, command, time_step, frame_number, once_mode,
                  input ready);
  modport sink   (input valid, command, time_step, frame_number, once_mode,
                  output ready);
endinterface

>>> design/sfs_res_if.sv
`timescale 1ns / 1ps

interface sfs_res_if import sfs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  is_playing;
  logic [LIST_POS_W-1:0] list_position;
  logic [FRAME_W-1:0]    current_frame;
  logic [COORD_W-1:0]    source_x;
  logic [COORD_W-1:0]    source_y;
  logic                  frame_valid;

  modport source (output valid, status, is_playing, list_position, current_frame,
                  source_x, source_y, frame_valid, input ready);
  modport sink   (input valid, status, is_playing, list_position, current_frame,
                  source_x, source_y, frame_valid, output ready);
endinterface

>>> design/sprite_frame_sequencer.sv
// Sprite-sheet animation sequencer. Each command transaction on cmd (tick, clear,
// append, start, stop, resume) yields exactly one result transaction on res with
// the status, play state, list position and the current frame's pixel origin in
// the sheet. Most of the work of a transaction, from acceptance until its result is
// offered, is the 16-step serial divider that splits the frame index
// into column and row, followed by two passes through one shared multiplier.
// cmd.ready is low while a transaction is in work; a finished result waits in the
// output register, so the next command can be taken before it is collected.
// Registers are written via cfg_write/cfg_index/cfg_data only while idle, a rule
// for the user, not enforced by the block; a zero frame delay write is ignored.
`timescale 1ns / 1ps

`include "sprite_frame_sequencer_assert.svh"

module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int MAX_LIST = MAX_LIST_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sfs_cmd_if.sink               cmd,
  sfs_res_if.source             res
);

  localparam int LW = $clog2(MAX_LIST + 1);
  localparam int PW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TICK,
    S_READ,
    S_DIVGO,
    S_DIVWAIT,
    S_MULX,
    S_MULY,
    S_OUT
  } state_t;

  state_t state;

  logic [GEOM_W-1:0] sheet_columns;
  logic [GEOM_W-1:0] sheet_rows;
  logic [GEOM_W-1:0] frame_width;
  logic [GEOM_W-1:0] frame_height;
  logic [TIME_W-1:0] frame_period;
  logic [AREA_W-1:0] sheet_area;

  logic [FRAME_W-1:0] frame_list [MAX_LIST];
  logic [FRAME_W-1:0] rd_frame;

  logic [LW-1:0]     list_length;
  logic [PW-1:0]     play_position;
  logic [CD_W-1:0]   countdown;
  logic              playing;
  logic              once;

  logic [CMD_W-1:0]   cur_command;
  logic [TIME_W-1:0]  cur_time_step;
  logic [FRAME_W-1:0] cur_frame_number;
  logic               cur_once;
  logic               tick_live;
  logic               frame_ok;
  status_t            status;
  logic [COORD_W-1:0] src_x;
  logic [MUL_W-1:0]   mul_res;

  logic [LW-1:0]      pos_ext;
  logic               cd_nonpos;
  logic               area_hit;
  logic               list_full;
  logic               append_ok;
  logic [CD_W+1:0]    cd_sub;
  logic               cd_sat;
  logic [GEOM_W-1:0]  mul_a;
  logic [FRAME_W-1:0] mul_b;
  logic [MUL_W-1:0]   mul_prod;

  sfs_div_req_t  div_req;
  sfs_div_resp_t div_resp;

  sfs_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign cmd.ready = (state == S_IDLE);

  assign pos_ext   = LW'(play_position);
  assign cd_nonpos = countdown[CD_W-1] || (countdown == '0);
  assign area_hit  = AREA_W'(cur_frame_number) >= sheet_area;
  assign list_full = list_length >= LW'(MAX_LIST);
  assign append_ok = (state == S_EXEC) && (cur_command == CMD_APPEND) &&
                     !area_hit && !list_full;

  // countdown - time_step, saturating at the most negative value
  assign cd_sub = {countdown[CD_W-1], countdown[CD_W-1], countdown} -
                  (CD_W + 2)'(cur_time_step);
  assign cd_sat = cd_sub[CD_W+1] && !(cd_sub[CD_W] && cd_sub[CD_W-1]);

  assign div_req.start    = (state == S_DIVGO);
  assign div_req.dividend = frame_ok ? rd_frame : '0;
  assign div_req.divisor  = (sheet_columns == '0) ? GEOM_W'(1) : sheet_columns;

  assign mul_a    = (state == S_MULX) ? frame_width : frame_height;
  assign mul_b    = (state == S_MULX) ? FRAME_W'(div_resp.remainder) : div_resp.quotient;
  assign mul_prod = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_columns <= GEOM_RESET;
      sheet_rows    <= GEOM_RESET;
      frame_width   <= GEOM_RESET;
      frame_height  <= GEOM_RESET;
      frame_period  <= DELAY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: sheet_columns <= cfg_data[GEOM_W-1:0];
        REG_ROWS:    sheet_rows    <= cfg_data[GEOM_W-1:0];
        REG_WIDTH:   frame_width   <= cfg_data[GEOM_W-1:0];
        REG_HEIGHT:  frame_height  <= cfg_data[GEOM_W-1:0];
        REG_DELAY: begin
          if (cfg_data[TIME_W-1:0] != '0) frame_period <= cfg_data[TIME_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sheet_area <= AREA_W'(sheet_columns) * AREA_W'(sheet_rows);
  end

  always_ff @(posedge clk) begin
    if (append_ok) frame_list[list_length[PW-1:0]] <= cur_frame_number;
    if (state == S_READ) rd_frame <= frame_list[play_position];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      list_length   <= '0;
      play_position <= '0;
      countdown     <= '0;
      playing       <= 1'b0;
      once          <= 1'b0;
      tick_live     <= 1'b0;
      frame_ok      <= 1'b0;
      status        <= ST_OK;
      res.valid     <= 1'b0;
    end else begin
      if (res.valid && res.ready && state != S_OUT) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cur_command      <= cmd.command;
            cur_time_step    <= cmd.time_step;
            cur_frame_number <= cmd.frame_number;
            cur_once         <= cmd.once_mode;
            state            <= S_EXEC;
          end
        end
        S_EXEC: begin
          status    <= ST_OK;
          tick_live <= (cur_command == CMD_TICK) && playing;
          unique case (cur_command)
            CMD_TICK: begin
              if (playing && cd_nonpos) begin
                if (list_length != '0 && (pos_ext + LW'(1)) < list_length) begin
                  play_position <= play_position + PW'(1);
                end else if (once) begin
                  playing <= 1'b0;
                end else begin
                  play_position <= '0;
                end
                countdown <= countdown + CD_W'(frame_period);
              end
            end
            CMD_CLEAR: begin
              list_length   <= '0;
              play_position <= '0;
              countdown     <= CD_W'(frame_period);
              playing       <= 1'b0;
            end
            CMD_APPEND: begin
              if (area_hit) status <= ST_RANGE;
              else if (list_full) status <= ST_FULL;
              else list_length <= list_length + LW'(1);
            end
            CMD_START: begin
              if (list_length == '0 || playing) begin
                status <= ST_REFUSED;
              end else begin
                play_position <= '0;
                countdown     <= CD_W'(frame_period);
                playing       <= 1'b1;
                once          <= cur_once;
              end
            end
            CMD_STOP: begin
              if (!playing) status <= ST_REFUSED;
              else playing <= 1'b0;
            end
            CMD_RESUME: begin
              if (list_length == '0) status <= ST_REFUSED;
              else playing <= 1'b1;
            end
            default: status <= ST_REFUSED;
          endcase
          state <= S_TICK;
        end
        S_TICK: begin
          if (tick_live) begin
            countdown <= cd_sat ? {1'b1, {(CD_W-1){1'b0}}} : cd_sub[CD_W-1:0];
          end
          state <= S_READ;
        end
        S_READ: begin
          frame_ok <= (list_length != '0) && (pos_ext < list_length);
          state    <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_resp.done) state <= S_MULX;
        end
        S_MULX: begin
          mul_res <= mul_prod;
          state   <= S_MULY;
        end
        S_MULY: begin
          src_x   <= mul_res[COORD_W-1:0];
          mul_res <= mul_prod;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.status        <= status;
            res.is_playing    <= playing;
            res.list_position <= LIST_POS_W'(play_position);
            res.current_frame <= frame_ok ? rd_frame : '0;
            res.source_x      <= src_x;
            res.source_y      <= mul_res[COORD_W-1:0];
            res.frame_valid   <= frame_ok;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SFS_ASSERT_IMP(a_pos_in_list, clk, rst, list_length != '0, pos_ext < list_length)
  `SFS_ASSERT_IMP(a_play_needs_list, clk, rst, playing, list_length != '0)
  `SFS_ASSERT_IMP(a_div_done_wait, clk, rst, div_resp.done, state == S_DIVWAIT)
  `SFS_ASSERT_NXT(a_append_grows, clk, rst, append_ok, list_length == $past(list_length) + LW'(1))

endmodule

>>> design/sfs_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sfs_divider import sfs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  sfs_div_req_t  req,
  output sfs_div_resp_t resp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [FRAME_W-1:0]   quo;
  logic [GEOM_W-1:0]    rem;
  logic [GEOM_W-1:0]    dvs;
  logic [GEOM_W:0]      shifted;
  logic [GEOM_W:0]      diff;
  logic                 take;

  assign shifted = {rem, quo[FRAME_W-1]};
  assign take    = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(FRAME_W);
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= take ? diff[GEOM_W-1:0] : shifted[GEOM_W-1:0];
        quo <= {quo[FRAME_W-2:0], take};
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done      = done;
  assign resp.quotient  = quo;
  assign resp.remainder = rem;

endmodule
